### rtl/ihq_pkg.sv
package ihq_pkg;

    // Default sizes of the heap and of the stored keys.
    localparam int MAX_VARS_DEF = 1024;
    localparam int KEY_BITS_DEF = 32;

    // Fixed widths of the ports.
    localparam int OP_W     = 2;
    localparam int VID_W    = 10;
    localparam int KEYIN_W  = 32;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 11;
    localparam int CFG_W    = 11;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_TAKE   = 2'd1,
        OP_UPDATE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_PRESENT = 3'd3,
        ST_ABSENT  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_DECIDE,
        S_TAKE_A,
        S_TAKE_B,
        S_TAKE_C,
        S_DN_L,
        S_DN_R,
        S_DN_KL,
        S_DN_KR,
        S_UP_P,
        S_UP_KP,
        S_UP_CMP,
        S_FINISH
    } state_t;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_CLEAR,
        CMD_ACCEPT,
        CMD_CHECK,
        CMD_DECIDE,
        CMD_TAKE_A,
        CMD_TAKE_B,
        CMD_TAKE_C,
        CMD_DN_L,
        CMD_DN_R,
        CMD_DN_KL,
        CMD_DN_KR,
        CMD_UP_P,
        CMD_UP_KP,
        CMD_UP_CMP,
        CMD_FINISH
    } cmd_op_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        cmd_op_t op;
        logic    place;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic    clear_last;
        op_t     op;
        status_t dec_status;
        logic    count_zero;
        logic    dn_no_left;
        logic    dn_stop;
        logic    at_start;
        logic    up_root;
        logic    up_move;
        logic    out_busy;
    } dp_status_t;

endpackage

### rtl/indexed_max_heap_queue_top.sv
// After an input transfer an operation passes the check and decide states, then walks
// the heap. A take steps through TAKE_A and TAKE_B, then TAKE_C and a sift-down if any
// entries remain; a sift-down runs DN_L, DN_R, DN_KL and DN_KR per child comparison
// and stops at a leaf after DN_L; a sift-up runs UP_P, UP_KP and UP_CMP per level.
// Insert sifts up. One operation at a time; an untaken result holds off the next one.
// Reset: the slot table is swept clear before input is taken; config writes go any time.
module indexed_max_heap_queue_top
    import ihq_pkg::*;
#(
    parameter int MAX_VARS = MAX_VARS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     op,
    input  logic [VID_W-1:0]    var_id,
    input  logic [KEYIN_W-1:0]  key_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [VID_W-1:0]    out_var,
    output logic [KEYIN_W-1:0]  out_key,
    output logic [OCC_W-1:0]    occupancy,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    cmd_t       cmd;
    dp_status_t st;

    ihq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .st       (st),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    ihq_dp #(.MAX_VARS(MAX_VARS), .KEY_BITS(KEY_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_valid  (in_valid),
        .op        (op),
        .var_id    (var_id),
        .key_value (key_value),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .status    (status),
        .out_var   (out_var),
        .out_key   (out_key),
        .occupancy (occupancy)
    );

    // A transfer in starts work, so the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an operation is in progress");

    // An empty report always comes with an empty heap.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_W'(ST_EMPTY) |-> occupancy == '0)
        else $error("empty status with nonzero occupancy");

    // Only a successful take returns a variable and key.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_W'(ST_OK) |-> out_var == '0 && out_key == '0)
        else $error("failed operation returned data");

    // Occupancy never exceeds the heap depth.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(occupancy) <= MAX_VARS)
        else $error("occupancy beyond heap depth");

endmodule

### rtl/ihq_ram.sv
module ihq_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/ihq_ctrl.sv
module ihq_ctrl
    import ihq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  dp_status_t st,
    output logic       in_ready,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (st.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (st.dec_status != ST_OK)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    case (st.op)
                        OP_INSERT: state_next = S_UP_P;
                        OP_TAKE:   state_next = S_TAKE_A;
                        OP_UPDATE: state_next = S_DN_L;
                        default:   state_next = S_FINISH;
                    endcase
                end
            end
            S_TAKE_A:
            begin
                state_next = S_TAKE_B;
            end
            S_TAKE_B:
            begin
                state_next = st.count_zero ? S_FINISH : S_TAKE_C;
            end
            S_TAKE_C:
            begin
                state_next = S_DN_L;
            end
            S_DN_L:
            begin
                if (st.dn_no_left)
                begin
                    state_next = st.at_start ? S_UP_P : S_FINISH;
                end
                else
                begin
                    state_next = S_DN_R;
                end
            end
            S_DN_R:
            begin
                state_next = S_DN_KL;
            end
            S_DN_KL:
            begin
                state_next = S_DN_KR;
            end
            S_DN_KR:
            begin
                if (st.dn_stop)
                begin
                    state_next = st.at_start ? S_UP_P : S_FINISH;
                end
                else
                begin
                    state_next = S_DN_L;
                end
            end
            S_UP_P:
            begin
                state_next = st.up_root ? S_FINISH : S_UP_KP;
            end
            S_UP_KP:
            begin
                state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                state_next = st.up_move ? S_UP_P : S_FINISH;
            end
            S_FINISH:
            begin
                if (!st.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd.op    = CMD_NOP;
        cmd.place = 1'b0;
        in_ready  = 1'b0;
        case (state_reg)
            S_CLEAR:  cmd.op = CMD_CLEAR;
            S_IDLE:
            begin
                cmd.op   = CMD_ACCEPT;
                in_ready = 1'b1;
            end
            S_CHECK:  cmd.op = CMD_CHECK;
            S_DECIDE: cmd.op = CMD_DECIDE;
            S_TAKE_A: cmd.op = CMD_TAKE_A;
            S_TAKE_B: cmd.op = CMD_TAKE_B;
            S_TAKE_C: cmd.op = CMD_TAKE_C;
            S_DN_L:
            begin
                cmd.op    = CMD_DN_L;
                cmd.place = st.dn_no_left && !st.at_start;
            end
            S_DN_R:   cmd.op = CMD_DN_R;
            S_DN_KL:  cmd.op = CMD_DN_KL;
            S_DN_KR:
            begin
                cmd.op    = CMD_DN_KR;
                cmd.place = st.dn_stop && !st.at_start;
            end
            S_UP_P:
            begin
                cmd.op    = CMD_UP_P;
                cmd.place = st.up_root;
            end
            S_UP_KP:  cmd.op = CMD_UP_KP;
            S_UP_CMP:
            begin
                cmd.op    = CMD_UP_CMP;
                cmd.place = !st.up_move;
            end
            S_FINISH: cmd.op = CMD_FINISH;
            default:  cmd.op = CMD_NOP;
        endcase
    end

endmodule

### rtl/ihq_dp.sv
module ihq_dp
    import ihq_pkg::*;
#(
    parameter int MAX_VARS = MAX_VARS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output dp_status_t          st,
    input  logic                in_valid,
    input  logic [OP_W-1:0]     op,
    input  logic [VID_W-1:0]    var_id,
    input  logic [KEYIN_W-1:0]  key_value,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [STATUS_W-1:0] status,
    output logic [VID_W-1:0]    out_var,
    output logic [KEYIN_W-1:0]  out_key,
    output logic [OCC_W-1:0]    occupancy
);

    localparam int VW = $clog2(MAX_VARS);
    localparam int CW = $clog2(MAX_VARS + 1);
    localparam int IW = VW + 2;
    localparam int SW = VW + 1;

    // Control registers.
    logic [CW-1:0]    count_reg;
    logic [CFG_W-1:0] active_reg;
    logic [VW-1:0]    clr_reg;
    logic             out_valid_reg;

    // Working registers.
    op_t                 op_reg;
    logic [VID_W-1:0]    v_reg;
    logic [KEYIN_W-1:0]  key_reg;
    logic [KEY_BITS-1:0] k_reg;
    logic [VW-1:0]       m_reg;
    logic [VW-1:0]       i_reg;
    logic [VW-1:0]       s_reg;
    logic                upd_reg;
    logic [VW-1:0]       lvar_reg;
    logic [VW-1:0]       rvar_reg;
    logic [VW-1:0]       pvar_reg;
    logic [KEY_BITS-1:0] lkey_reg;
    logic [VW-1:0]       ovar_reg;
    logic [KEY_BITS-1:0] okey_reg;
    status_t             stat_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [VID_W-1:0]    out_var_reg;
    logic [KEYIN_W-1:0]  out_key_reg;
    logic [OCC_W-1:0]    occ_reg;

    // Memory ports.
    logic                hs_we;
    logic [VW-1:0]       hs_waddr;
    logic [VW-1:0]       hs_wdata;
    logic [VW-1:0]       hs_raddr;
    logic [VW-1:0]       hs_rd;
    logic                sv_we;
    logic [VW-1:0]       sv_waddr;
    logic [SW-1:0]       sv_wdata;
    logic [VW-1:0]       sv_raddr;
    logic [SW-1:0]       sv_rd;
    logic                ky_we;
    logic [VW-1:0]       ky_waddr;
    logic [KEY_BITS-1:0] ky_wdata;
    logic [VW-1:0]       ky_raddr;
    logic [KEY_BITS-1:0] ky_rd;

    // Index arithmetic and decisions.
    logic [IW-1:0]       l_w;
    logic [IW-1:0]       r_w;
    logic [IW-1:0]       cnt_w;
    logic                r_valid;
    logic [VW-1:0]       p_idx;
    logic                take_l;
    logic                take_r;
    logic [KEY_BITS-1:0] best_key;
    logic                dn_stop;
    logic [VW-1:0]       best_idx;
    logic [VW-1:0]       best_var;
    logic                up_move;
    logic                vid_bad;
    logic                full;
    logic [31:0]         cap;
    status_t             dec_status;
    logic                dec_ok;
    logic                out_busy;

    ihq_ram #(.WIDTH(VW), .DEPTH(MAX_VARS)) u_heap_slots (
        .clk   (clk),
        .we    (hs_we),
        .waddr (hs_waddr),
        .wdata (hs_wdata),
        .raddr (hs_raddr),
        .rdata (hs_rd)
    );

    ihq_ram #(.WIDTH(SW), .DEPTH(MAX_VARS)) u_slot_of_var (
        .clk   (clk),
        .we    (sv_we),
        .waddr (sv_waddr),
        .wdata (sv_wdata),
        .raddr (sv_raddr),
        .rdata (sv_rd)
    );

    ihq_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_VARS)) u_var_keys (
        .clk   (clk),
        .we    (ky_we),
        .waddr (ky_waddr),
        .wdata (ky_wdata),
        .raddr (ky_raddr),
        .rdata (ky_rd)
    );

    // Child and parent slots of the current hole.
    assign l_w     = IW'({i_reg, 1'b1});
    assign r_w     = l_w + IW'(1);
    assign cnt_w   = IW'(count_reg);
    assign r_valid = r_w < cnt_w;
    assign p_idx   = (i_reg - VW'(1)) >> 1;

    // Sift-down choice: left child wins ties, a child moves only if strictly greater.
    always_comb
    begin
        take_l   = lkey_reg > k_reg;
        best_key = take_l ? lkey_reg : k_reg;
        take_r   = r_valid && (ky_rd > best_key);
        dn_stop  = !take_l && !take_r;
        best_idx = take_r ? r_w[VW-1:0] : l_w[VW-1:0];
        best_var = take_r ? rvar_reg : lvar_reg;
    end

    // Sift-up moves the parent down while it is strictly smaller.
    assign up_move = ky_rd < k_reg;

    // Checks of a new operation.
    assign cap     = (32'(active_reg) < MAX_VARS) ? 32'(active_reg) : MAX_VARS;
    assign vid_bad = 32'(v_reg) >= MAX_VARS;
    assign full    = 32'(count_reg) >= cap;

    always_comb
    begin
        case (op_reg)
            OP_INSERT:
            begin
                if (vid_bad)
                begin
                    dec_status = ST_ABSENT;
                end
                else if (sv_rd[VW])
                begin
                    dec_status = ST_PRESENT;
                end
                else if (full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_status = ST_OK;
                end
            end
            OP_TAKE:   dec_status = (count_reg == '0) ? ST_EMPTY : ST_OK;
            OP_UPDATE: dec_status = (vid_bad || !sv_rd[VW]) ? ST_ABSENT : ST_OK;
            default:   dec_status = ST_OK;
        endcase
    end

    assign dec_ok   = dec_status == ST_OK;
    assign out_busy = out_valid_reg && !out_ready;

    // Status to the controller.
    always_comb
    begin
        st.clear_last = clr_reg == VW'(MAX_VARS - 1);
        st.op         = op_reg;
        st.dec_status = dec_status;
        st.count_zero = count_reg == '0;
        st.dn_no_left = !(l_w < cnt_w);
        st.dn_stop    = dn_stop;
        st.at_start   = upd_reg && (i_reg == s_reg);
        st.up_root    = i_reg == '0;
        st.up_move    = up_move;
        st.out_busy   = out_busy;
    end

    // Memory addressing for each command.
    always_comb
    begin
        hs_we    = 1'b0;
        hs_waddr = '0;
        hs_wdata = '0;
        hs_raddr = '0;
        sv_we    = 1'b0;
        sv_waddr = '0;
        sv_wdata = '0;
        sv_raddr = '0;
        ky_we    = 1'b0;
        ky_waddr = '0;
        ky_wdata = '0;
        ky_raddr = '0;
        case (cmd.op)
            CMD_CLEAR:
            begin
                sv_we    = 1'b1;
                sv_waddr = clr_reg;
            end
            CMD_CHECK:
            begin
                sv_raddr = VW'(v_reg);
            end
            CMD_DECIDE:
            begin
                if (dec_ok && (op_reg == OP_INSERT || op_reg == OP_UPDATE))
                begin
                    ky_we    = 1'b1;
                    ky_waddr = VW'(v_reg);
                    ky_wdata = KEY_BITS'(key_reg);
                end
                else if (dec_ok && op_reg == OP_TAKE)
                begin
                    // The taken variable leaves the heap.
                    sv_we    = 1'b1;
                    sv_waddr = hs_rd;
                end
            end
            CMD_TAKE_A:
            begin
                ky_raddr = ovar_reg;
                hs_raddr = VW'(count_reg);
            end
            CMD_TAKE_B: ky_raddr = hs_rd;
            CMD_DN_L:   hs_raddr = l_w[VW-1:0];
            CMD_DN_R:
            begin
                ky_raddr = hs_rd;
                hs_raddr = r_w[VW-1:0];
            end
            CMD_DN_KL:  ky_raddr = hs_rd;
            CMD_DN_KR:
            begin
                if (!dn_stop)
                begin
                    hs_we    = 1'b1;
                    hs_waddr = i_reg;
                    hs_wdata = best_var;
                    sv_we    = 1'b1;
                    sv_waddr = best_var;
                    sv_wdata = {1'b1, i_reg};
                end
            end
            CMD_UP_P:   hs_raddr = p_idx;
            CMD_UP_KP:  ky_raddr = hs_rd;
            CMD_UP_CMP:
            begin
                if (up_move)
                begin
                    hs_we    = 1'b1;
                    hs_waddr = i_reg;
                    hs_wdata = pvar_reg;
                    sv_we    = 1'b1;
                    sv_waddr = pvar_reg;
                    sv_wdata = {1'b1, i_reg};
                end
            end
            default:
            begin
                hs_raddr = '0;
            end
        endcase
        // Put the moving variable into the final hole.
        if (cmd.place)
        begin
            hs_we    = 1'b1;
            hs_waddr = i_reg;
            hs_wdata = m_reg;
            sv_we    = 1'b1;
            sv_waddr = m_reg;
            sv_wdata = {1'b1, i_reg};
        end
    end

    // Control registers with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            active_reg    <= ACTIVE_RESET;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
            if (cmd.op == CMD_CLEAR)
            begin
                clr_reg <= clr_reg + VW'(1);
            end
            if (cmd.op == CMD_DECIDE && dec_ok && op_reg == OP_INSERT)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.op == CMD_DECIDE && dec_ok && op_reg == OP_TAKE)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.op == CMD_FINISH && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CMD_ACCEPT:
            begin
                if (in_valid)
                begin
                    op_reg  <= op_t'(op);
                    v_reg   <= var_id;
                    key_reg <= key_value;
                end
            end
            CMD_DECIDE:
            begin
                stat_reg <= dec_status;
                upd_reg  <= dec_ok && (op_reg == OP_UPDATE);
                if (dec_ok)
                begin
                    case (op_reg)
                        OP_INSERT:
                        begin
                            k_reg <= KEY_BITS'(key_reg);
                            m_reg <= VW'(v_reg);
                            i_reg <= VW'(count_reg);
                        end
                        OP_TAKE:
                        begin
                            ovar_reg <= hs_rd;
                        end
                        OP_UPDATE:
                        begin
                            k_reg <= KEY_BITS'(key_reg);
                            m_reg <= VW'(v_reg);
                            i_reg <= sv_rd[VW-1:0];
                            s_reg <= sv_rd[VW-1:0];
                        end
                        default: ;
                    endcase
                end
            end
            CMD_TAKE_B:
            begin
                okey_reg <= ky_rd;
                m_reg    <= hs_rd;
            end
            CMD_TAKE_C:
            begin
                k_reg <= ky_rd;
                i_reg <= '0;
            end
            CMD_DN_R:  lvar_reg <= hs_rd;
            CMD_DN_KL:
            begin
                lkey_reg <= ky_rd;
                rvar_reg <= hs_rd;
            end
            CMD_DN_KR:
            begin
                if (!dn_stop)
                begin
                    i_reg <= best_idx;
                end
            end
            CMD_UP_KP: pvar_reg <= hs_rd;
            CMD_UP_CMP:
            begin
                if (up_move)
                begin
                    i_reg <= p_idx;
                end
            end
            CMD_FINISH:
            begin
                if (!out_busy)
                begin
                    status_reg <= stat_reg;
                    occ_reg    <= OCC_W'(count_reg);
                    if (op_reg == OP_TAKE && stat_reg == ST_OK)
                    begin
                        out_var_reg <= VID_W'(ovar_reg);
                        out_key_reg <= KEYIN_W'(okey_reg);
                    end
                    else
                    begin
                        out_var_reg <= '0;
                        out_key_reg <= '0;
                    end
                end
            end
            default:
            begin
                upd_reg <= upd_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_var   = out_var_reg;
    assign out_key   = out_key_reg;
    assign occupancy = occ_reg;

endmodule
